[hw/rtl/ntad_pkg.sv]
// Package for the number to ASCII digits block.
// Holds word types, mode codes, ASCII constants and controller/datapath links.
// No dependencies.
`default_nettype none

package ntad_pkg;

  localparam logic [1:0] OP_UDEC = 2'd0;
  localparam logic [1:0] OP_SDEC = 2'd1;
  localparam logic [1:0] OP_HEX  = 2'd2;
  localparam logic [1:0] OP_BIN  = 2'd3;

  localparam logic [6:0] ASCII_ZERO  = 7'h30;
  localparam logic [6:0] ASCII_A     = 7'h41;
  localparam logic [6:0] ASCII_PLUS  = 7'h2B;
  localparam logic [6:0] ASCII_MINUS = 7'h2D;

  localparam logic [5:0] MAX_DIGITS = 6'd32;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] value;
    logic [5:0]  digit_count;
    logic [2:0]  line;
    logic [4:0]  start_column;
  } in_word_t;

  typedef struct packed {
    logic [2:0] out_line;
    logic [7:0] column;
    logic [6:0] char_code;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_dec;
    logic is_signed;
    logic conv_last;
    logic rem_zero;
    logic rem_one;
  } sts_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] ch;
    if (d < 4'd10) begin
      ch = ASCII_ZERO + {3'b000, d};
    end else begin
      ch = ASCII_A + {3'b000, d} - 7'd10;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ntad_dp.sv]
// Datapath: request registers, double-dabble converter, digit select, output word.
// Depends on ntad_pkg.
`default_nettype none

module ntad_dp (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  ntad_pkg::in_word_t    in_word_i,
  input  ntad_pkg::cmd_t        cmd_i,
  output ntad_pkg::sts_t        sts_o,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output ntad_pkg::out_word_t   out_word_o
);

  logic [1:0]  mode_q, mode_d;
  logic        neg_q, neg_d;
  logic [31:0] mag_q, mag_d;
  logic [39:0] bcd_q, bcd_d;
  logic [4:0]  conv_cnt_q, conv_cnt_d;
  logic [5:0]  rem_q, rem_d;
  logic [4:0]  pos_q, pos_d;
  logic [7:0]  col_q, col_d;
  logic [2:0]  line_q, line_d;
  logic        out_valid_q, out_valid_d;
  ntad_pkg::out_word_t out_word_q, out_word_d;

  logic [5:0]  count_clamped;
  logic [39:0] bcd_adj;
  logic [39:0] bcd_sh;
  logic [31:0] hex_sh;
  logic [31:0] bin_sh;
  logic [3:0]  digit;

  assign count_clamped = (in_word_i.digit_count > ntad_pkg::MAX_DIGITS) ?
                         ntad_pkg::MAX_DIGITS : in_word_i.digit_count;

  always_comb begin
    for (int k = 0; k < 10; k++) begin
      bcd_adj[k*4 +: 4] = (bcd_q[k*4 +: 4] >= 4'd5) ? bcd_q[k*4 +: 4] + 4'd3 :
                                                      bcd_q[k*4 +: 4];
    end
  end

  assign bcd_sh = bcd_q >> {pos_q, 2'b00};
  assign hex_sh = mag_q >> {pos_q, 2'b00};
  assign bin_sh = mag_q >> pos_q;

  always_comb begin
    case (mode_q)
      ntad_pkg::OP_HEX: digit = hex_sh[3:0];
      ntad_pkg::OP_BIN: digit = {3'b000, bin_sh[0]};
      default:          digit = bcd_sh[3:0];
    endcase
  end

  always_comb begin
    mode_d      = mode_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    conv_cnt_d  = conv_cnt_q;
    rem_d       = rem_q;
    pos_d       = pos_q;
    col_d       = col_q;
    line_d      = line_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cmd_i.load) begin
      mode_d     = in_word_i.opcode;
      neg_d      = (in_word_i.opcode == ntad_pkg::OP_SDEC) && in_word_i.value[31];
      mag_d      = neg_d ? (32'd0 - in_word_i.value) : in_word_i.value;
      bcd_d      = '0;
      conv_cnt_d = '0;
      rem_d      = count_clamped;
      pos_d      = 5'(count_clamped - 6'd1);
      col_d      = {3'b000, in_word_i.start_column};
      line_d     = in_word_i.line;
    end

    if (cmd_i.conv_step) begin
      bcd_d      = {bcd_adj[38:0], mag_q[31]};
      mag_d      = {mag_q[30:0], 1'b0};
      conv_cnt_d = conv_cnt_q + 5'd1;
    end

    if (cmd_i.emit_sign) begin
      out_valid_d          = 1'b1;
      out_word_d.out_line  = line_q;
      out_word_d.column    = col_q;
      out_word_d.char_code = neg_q ? ntad_pkg::ASCII_MINUS : ntad_pkg::ASCII_PLUS;
      out_word_d.last      = (rem_q == 6'd0);
      col_d                = col_q + 8'd1;
    end

    if (cmd_i.emit_digit) begin
      out_valid_d          = 1'b1;
      out_word_d.out_line  = line_q;
      out_word_d.column    = col_q;
      out_word_d.char_code = ntad_pkg::digit_char(digit);
      out_word_d.last      = (rem_q == 6'd1);
      col_d                = col_q + 8'd1;
      rem_d                = rem_q - 6'd1;
      pos_d                = pos_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      conv_cnt_q  <= '0;
      mode_q      <= ntad_pkg::OP_UDEC;
    end else begin
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
      conv_cnt_q  <= conv_cnt_d;
      mode_q      <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    pos_q      <= pos_d;
    col_q      <= col_d;
    line_q     <= line_d;
    out_word_q <= out_word_d;
  end

  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.is_dec    = mode_q inside {ntad_pkg::OP_UDEC, ntad_pkg::OP_SDEC};
  assign sts_o.is_signed = (mode_q == ntad_pkg::OP_SDEC);
  assign sts_o.conv_last = (conv_cnt_q == 5'd31);
  assign sts_o.rem_zero  = (rem_q == 6'd0);
  assign sts_o.rem_one   = (rem_q == 6'd1);

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.load, cmd_i.conv_step, cmd_i.emit_sign, cmd_i.emit_digit}))
    else $error("more than one datapath command");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_sign || cmd_i.emit_digit) |-> sts_o.out_free)
    else $error("word emitted over a held output");

  a_digit_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_digit |-> (rem_q != 6'd0))
    else $error("digit emitted with none remaining");

  a_conv_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.conv_step |-> sts_o.is_dec)
    else $error("conversion step outside decimal mode");
`endif

endmodule

`default_nettype wire

[hw/rtl/ntad_ctrl.sv]
// Controller state machine: sequences load, conversion and character emission.
// Depends on ntad_pkg.
`default_nettype none

module ntad_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  ntad_pkg::sts_t  sts_i,
  output ntad_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_CONV  = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.is_dec) begin
          state_d = ST_CONV;
        end else if (sts_i.rem_zero) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (sts_i.conv_last) begin
          if (sts_i.is_signed) begin
            state_d = ST_SIGN;
          end else if (sts_i.rem_zero) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_DIGIT;
          end
        end
      end
      ST_SIGN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = sts_i.rem_zero ? ST_IDLE : ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.rem_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_CHECK))
    else $error("load not followed by check");

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input taken while busy");

  a_digit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_digit && sts_i.rem_one) |=> (state_q == ST_IDLE))
    else $error("last digit did not end the request");
`endif

endmodule

`default_nettype wire

[hw/rtl/number_to_ascii_digits.sv]
// Top level of the number to ASCII digits block.
// Instantiates ntad_ctrl and ntad_dp; depends on ntad_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) takes one request
//   word: mode, 32-bit value, digit count, line and start column.
//   Output channel (out_valid_o / out_stall_i / out_word_o) returns one word
//   per character, most significant digit first, last set on the final one.
//   Signed decimal sends the sign character before the digits.
//   Sequence: after accept the request is decoded in the check state. Decimal
//   modes then run the double-dabble conversion before the first character
//   shows; hex and binary go from the check state straight to the characters.
//   Characters then leave at one per cycle while out_stall_i is low.
//   Request time is set by the one-bit-per-cycle decimal converter and the
//   single output register. The next request is taken once the last character
//   sits in the output register.
//   Reset clears the controller and the output valid; no word is in flight.
//   While out_stall_i is high a valid output word holds and emission pauses.
`default_nettype none

module number_to_ascii_digits (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  ntad_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output ntad_pkg::out_word_t  out_word_o
);

  ntad_pkg::cmd_t cmd;
  ntad_pkg::sts_t sts;

  ntad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ntad_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
